FILE: rtl/core/stdes_pkg.sv
// shared types, constants and exponential tables of the dual-exponential synapse
package stdes_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int FRAC_BITS = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_INT_SPAN = 24;
    localparam int INT_IDX_W = $clog2(EXP_INT_SPAN);
    localparam logic [63:0] Q30_ONE = 64'd1073741824;

    // register indexes
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_PEAK_COND = 3'd1;
    localparam logic [2:0] REG_NORM = 3'd2;
    localparam logic [2:0] REG_RISE = 3'd3;
    localparam logic [2:0] REG_DECAY = 3'd4;
    localparam logic [2:0] REG_REVERSAL = 3'd5;
    localparam logic [2:0] REG_INIT_FIRE = 3'd6;
    localparam logic [2:0] REG_START_FIRED = 3'd7;

    // datapath commands from the controller
    typedef struct packed {
        logic load_in;    // capture item, run detection and state update
        logic exp_sel;    // 0 decay, 1 rise
        logic exp_mul;    // form exponent product x = e * rate
        logic exp_tab;    // table lookup for the selected exponential
        logic exp_lerp;   // interpolation step
        logic exp_scale;  // integer-part scaling, store result
        logic mul_a;      // norm * gmax and diff
        logic mul_p;      // a * |g|
        logic mul_m;      // p * |dv|
        logic finish;     // saturate and load output register
    } stdes_cmd_t;

    // constant table types: fraction table and integer-part table, Q1.30
    typedef logic [EXP_TABLE_DEPTH:0][31:0] frac_tab_t;
    typedef logic [EXP_INT_SPAN-1:0][31:0] int_tab_t;

    // exp(-y), y in Q1.30, truncated series as in the table build
    function automatic logic [31:0] series_exp_neg(input logic [63:0] y);
        logic signed [63:0] sum;
        logic [63:0] term;
        sum = 64'sd1073741824;
        term = Q30_ONE;
        for (int i = 1; i <= 24; i++) begin
            term = ((term * y) >> 30) / 64'(i);
            if ((i % 2) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return sum[31:0];
    endfunction

    function automatic logic [31:0] frac_entry(input int k);
        return series_exp_neg((64'(k) << 30) / 64'(EXP_TABLE_DEPTH));
    endfunction

    // exp(-k/depth) for every fraction step
    function automatic frac_tab_t build_frac_tab();
        frac_tab_t t;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++)
            t[k] = frac_entry(k);
        return t;
    endfunction

    // exp(-n) by rounded repeated multiplication of exp(-1)
    function automatic int_tab_t build_int_tab();
        int_tab_t t;
        logic [63:0] v;
        logic [63:0] e1;
        v = Q30_ONE;
        e1 = 64'(frac_entry(EXP_TABLE_DEPTH));
        t[0] = v[31:0];
        for (int k = 1; k < EXP_INT_SPAN; k++) begin
            v = (v * e1 + (Q30_ONE >> 1)) >> 30;
            t[k] = v[31:0];
        end
        return t;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();
    localparam int_tab_t INT_TAB = build_int_tab();

endpackage

FILE: rtl/core/spike_triggered_dual_exp_synapse.sv
// top level of the spike-triggered dual-exponential synapse
// one item at a time: a new item is accepted only once the controller is back in idle,
// after the previous item's result has been loaded into the output register
// the shared exponential unit (decay then rise) and the three-step product chain run in turn
// reset sets the configuration registers to their defaults and the synapse to never fired
module spike_triggered_dual_exp_synapse (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pre_voltage[15:0], post_voltage[31:16], sim_time[63:32]
    input  logic        s_tuser,   // first_step
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // synaptic_current[31:0], spike_detected[32], zeros
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_data
);

    stdes_pkg::stdes_cmd_t cmd;
    logic busy, in_fire, out_free;
    logic signed [31:0] res_current;
    logic res_spike;
    logic mvalid_reg;

    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    stdes_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .busy(busy), .cmd(cmd)
    );

    stdes_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .first_step(s_tuser),
        .pre_voltage(s_tdata[15:0]), .post_voltage(s_tdata[31:16]),
        .sim_time(s_tdata[63:32]),
        .res_current(res_current), .res_spike(res_spike)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (cmd.finish)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {7'd0, res_spike, res_current};

endmodule

FILE: rtl/core/stdes_ctrl.sv
// controller sequencing one item through the shared exponential and product units
module stdes_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_free,
    output logic                  busy,
    output stdes_pkg::stdes_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DMUL = 4'd1;
    localparam logic [3:0] S_DTAB = 4'd2;
    localparam logic [3:0] S_DLRP = 4'd3;
    localparam logic [3:0] S_DSCL = 4'd4;
    localparam logic [3:0] S_RMUL = 4'd5;
    localparam logic [3:0] S_RTAB = 4'd6;
    localparam logic [3:0] S_RLRP = 4'd7;
    localparam logic [3:0] S_RSCL = 4'd8;
    localparam logic [3:0] S_MA = 4'd9;
    localparam logic [3:0] S_MP = 4'd10;
    localparam logic [3:0] S_MM = 4'd11;
    localparam logic [3:0] S_FIN = 4'd12;

    logic [3:0] state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_DMUL;
            S_DMUL: state_next = S_DTAB;
            S_DTAB: state_next = S_DLRP;
            S_DLRP: state_next = S_DSCL;
            S_DSCL: state_next = S_RMUL;
            S_RMUL: state_next = S_RTAB;
            S_RTAB: state_next = S_RLRP;
            S_RLRP: state_next = S_RSCL;
            S_RSCL: state_next = S_MA;
            S_MA:   state_next = S_MP;
            S_MP:   state_next = S_MM;
            S_MM:   state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // command decode
    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        cmd.load_in = (state_reg == S_IDLE) && in_fire;
        cmd.exp_sel = (state_reg == S_RMUL) || (state_reg == S_RTAB) ||
                      (state_reg == S_RLRP) || (state_reg == S_RSCL);
        cmd.exp_mul = (state_reg == S_DMUL) || (state_reg == S_RMUL);
        cmd.exp_tab = (state_reg == S_DTAB) || (state_reg == S_RTAB);
        cmd.exp_lerp = (state_reg == S_DLRP) || (state_reg == S_RLRP);
        cmd.exp_scale = (state_reg == S_DSCL) || (state_reg == S_RSCL);
        cmd.mul_a = (state_reg == S_MA);
        cmd.mul_p = (state_reg == S_MP);
        cmd.mul_m = (state_reg == S_MM);
        cmd.finish = (state_reg == S_FIN) && out_free;
    end

    // checks
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_DMUL) else $error("load did not start sequence");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE) else $error("finish did not return idle");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.exp_mul, cmd.exp_tab, cmd.exp_lerp, cmd.exp_scale,
                  cmd.mul_a, cmd.mul_p, cmd.mul_m, cmd.finish}))
        else $error("overlapping commands");

endmodule

FILE: rtl/core/stdes_dp.sv
// datapath: spike detection, fire state, exponentials, product and saturation
module stdes_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stdes_pkg::stdes_cmd_t cmd,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [31:0]           cfg_data,
    input  logic                  first_step,
    input  logic signed [15:0]    pre_voltage,
    input  logic signed [15:0]    post_voltage,
    input  logic [31:0]           sim_time,
    output logic signed [31:0]    res_current,
    output logic                  res_spike
);

    localparam int FB = stdes_pkg::FRAC_BITS;
    localparam int IW = stdes_pkg::INT_IDX_W;

    // configuration registers
    logic signed [15:0] threshold_reg;
    logic [15:0] peak_reg, norm_reg, rise_reg, decay_reg;
    logic signed [15:0] rev_reg;
    logic [31:0] init_fire_reg;
    logic start_fired_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            peak_reg <= '0;
            norm_reg <= 16'd4096;
            rise_reg <= '0;
            decay_reg <= '0;
            rev_reg <= -16'sd20480;
            init_fire_reg <= '0;
            start_fired_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                stdes_pkg::REG_THRESHOLD:   threshold_reg <= cfg_data[15:0];
                stdes_pkg::REG_PEAK_COND:   peak_reg <= cfg_data[15:0];
                stdes_pkg::REG_NORM:        norm_reg <= cfg_data[15:0];
                stdes_pkg::REG_RISE:        rise_reg <= cfg_data[15:0];
                stdes_pkg::REG_DECAY:       decay_reg <= cfg_data[15:0];
                stdes_pkg::REG_REVERSAL:    rev_reg <= cfg_data[15:0];
                stdes_pkg::REG_INIT_FIRE:   init_fire_reg <= cfg_data;
                stdes_pkg::REG_START_FIRED: start_fired_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // synapse state
    logic signed [15:0] last_pre_reg;
    logic last_valid_reg, has_fired_reg;
    logic [31:0] fire_time_reg;
    logic fired_eff, spike, valid_eff;
    logic [31:0] ft_eff;

    always_comb
    begin
        fired_eff = first_step ? start_fired_reg : has_fired_reg;
        ft_eff = first_step ? init_fire_reg : fire_time_reg;
        valid_eff = first_step ? 1'b0 : last_valid_reg;
        spike = valid_eff && (last_pre_reg < threshold_reg) && (pre_voltage > threshold_reg);
    end

    // item capture
    logic [31:0] elapsed_reg;
    logic fired_reg, spike_reg;
    logic signed [16:0] dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pre_reg <= '0;
            last_valid_reg <= 1'b0;
            has_fired_reg <= 1'b0;
            fire_time_reg <= '0;
        end
        else if (cmd.load_in)
        begin
            last_pre_reg <= pre_voltage;
            last_valid_reg <= 1'b1;
            has_fired_reg <= fired_eff || spike;
            fire_time_reg <= spike ? sim_time : ft_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            elapsed_reg <= spike ? 32'd0 :
                           ((sim_time >= ft_eff) ? sim_time - ft_eff : 32'd0);
            fired_reg <= fired_eff || spike;
            spike_reg <= spike;
            dv_reg <= 17'(post_voltage) - 17'(rev_reg);
        end
    end

    // exponential unit, shared by decay and rise
    logic [47:0] x_reg;
    logic [31:0] lo_reg, hi_reg, v_reg, ip_reg, ed_reg, er_reg;
    logic [15:0] w_reg;
    logic zero_reg;
    logic [15:0] rate;
    logic [FB+15:0] pos;
    logic [FB-1:0] k;
    logic [FB:0] kx;
    logic [15:0] w;
    logic [31:0] lo_t, hi_t, ip_t;
    logic [31:0] diff, lerp;
    logic [47:0] dw;
    logic [63:0] sc;

    always_comb
    begin
        rate = cmd.exp_sel ? rise_reg : decay_reg;
        pos = (FB+16)'(x_reg[15:0]) * (FB+16)'(stdes_pkg::EXP_TABLE_DEPTH);
        k = pos[FB+15:16];
        w = pos[15:0];
        kx = {1'b0, k};
        lo_t = stdes_pkg::FRAC_TAB[kx];
        hi_t = stdes_pkg::FRAC_TAB[kx + (FB+1)'(1)];
        ip_t = (x_reg[47:16] < 32'(stdes_pkg::EXP_INT_SPAN)) ?
               stdes_pkg::INT_TAB[x_reg[16+IW-1:16]] : 32'd0;
        diff = (lo_reg >= hi_reg) ? lo_reg - hi_reg : hi_reg - lo_reg;
        dw = 48'(diff) * 48'(w_reg);
        lerp = (lo_reg >= hi_reg) ? lo_reg - dw[47:16] : lo_reg + dw[47:16];
        sc = 64'(ip_reg) * 64'(v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exp_mul)
            x_reg <= 48'(elapsed_reg) * 48'(rate);
        if (cmd.exp_tab)
        begin
            lo_reg <= lo_t;
            hi_reg <= hi_t;
            w_reg <= w;
            ip_reg <= ip_t;
            zero_reg <= (x_reg[47:16] >= 32'(stdes_pkg::EXP_INT_SPAN));
        end
        if (cmd.exp_lerp)
            v_reg <= lerp;
        if (cmd.exp_scale)
        begin
            if (cmd.exp_sel)
                er_reg <= zero_reg ? 32'd0 : sc[61:30];
            else
                ed_reg <= zero_reg ? 32'd0 : sc[61:30];
        end
    end

    // product chain with rounding
    logic [31:0] a_reg, gm_reg;
    logic [31:0] p_reg;
    logic [43:0] mag_reg;
    logic neg_reg;
    logic [63:0] pa;
    logic [63:0] pm;
    logic [16:0] dm;

    always_comb
    begin
        dm = dv_reg[16] ? 17'(-dv_reg) : 17'(dv_reg);
        pa = 64'(a_reg) * 64'(gm_reg) + 64'h2000_0000;
        pm = 64'(p_reg) * 64'(dm) + 64'h8_0000;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
        begin
            a_reg <= 32'(norm_reg) * 32'(peak_reg);
            gm_reg <= (ed_reg >= er_reg) ? ed_reg - er_reg : er_reg - ed_reg;
            neg_reg <= !((ed_reg < er_reg) != dv_reg[16]);
        end
        if (cmd.mul_p)
            p_reg <= pa[61:30];
        if (cmd.mul_m)
            mag_reg <= pm[63:20];
    end

    // saturation and output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_spike <= spike_reg;
            if (!fired_reg || mag_reg == '0)
                res_current <= '0;
            else if (neg_reg)
                res_current <= (mag_reg >= 44'h8000_0000) ? 32'sh8000_0000 : -$signed(mag_reg[31:0]);
            else
                res_current <= (mag_reg >= 44'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag_reg[31:0]);
        end
    end

    // checks
    a_spike_fires: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_in && spike) |=> has_fired_reg) else $error("spike did not set fired");
    a_spike_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_in && spike) |=> fire_time_reg == $past(sim_time)) else $error("fire time");
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> last_valid_reg) else $error("sample not marked valid");

endmodule

FILE: verif/tb_spike_triggered_dual_exp_synapse.sv
// self-checking testbench of the spike-triggered dual-exponential synapse
module tb_spike_triggered_dual_exp_synapse;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETUP_ROW = 10;
    localparam int NUM_ROWS = 22;
    localparam int NUM_PHASES = 11;
    localparam int PHASE_ITEMS = 150;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // pre_voltage[15:0], post_voltage[31:16], sim_time[63:32]
    logic        s_tuser;   // first_step
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // synaptic_current[31:0], spike_detected[32], zeros
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    typedef struct {
        logic [31:0] current;
        logic        spike;
    } synapse_out_t;

    typedef struct {
        logic        first;
        logic [15:0] pre;
        logic [15:0] post;
        logic [31:0] tick;
        logic        typed;
        logic [31:0] current;
        logic        spike;
    } step_row_t;

    // predictor state and register shadow
    logic [31:0] reg_shadow [8];
    logic [15:0] prev_pre;
    logic        prev_valid;
    logic [31:0] fire_tick;
    logic        fired;
    logic [31:0] frac_lut [stdes_pkg::EXP_TABLE_DEPTH + 1];
    logic [31:0] int_lut [stdes_pkg::EXP_INT_SPAN];

    synapse_out_t current_q [$];
    int          errors;
    int          stall_left;
    int          idle_cycles;
    bit          idle_on;

    spike_triggered_dual_exp_synapse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // exp(-y) for y in Q1.30, truncated series
    function automatic logic [31:0] series_q30(input logic [63:0] y);
        logic signed [63:0] sum;
        logic [63:0] term;
        sum = 64'sd1073741824;
        term = 64'd1073741824;
        for (int i = 1; i <= 24; i++)
        begin
            term = ((term * y) >> 30) / 64'(i);
            if (i % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return sum[31:0];
    endfunction

    // exp(-x), x in Q48.16, result Q1.30
    function automatic logic [63:0] decay_q30(input logic [63:0] x);
        logic [63:0] n, pos, k, w, lo, hi, v;
        n = x >> 16;
        if (n >= stdes_pkg::EXP_INT_SPAN)
            return 0;
        pos = (x & 64'hFFFF) * stdes_pkg::EXP_TABLE_DEPTH;
        k = pos >> 16;
        w = pos & 64'hFFFF;
        if (k >= stdes_pkg::EXP_TABLE_DEPTH)
        begin
            k = stdes_pkg::EXP_TABLE_DEPTH - 1;
            w = 64'hFFFF;
        end
        lo = 64'(frac_lut[int'(k)]);
        hi = 64'(frac_lut[int'(k) + 1]);
        v = (lo >= hi) ? lo - (((lo - hi) * w) >> 16) : lo + (((hi - lo) * w) >> 16);
        return (64'(int_lut[int'(n)]) * v) >> 30;
    endfunction

    // one time step of the synapse: detection, state update and current
    function automatic synapse_out_t step_synapse(input logic first, input logic [15:0] pre,
                                                  input logic [15:0] post,
                                                  input logic [31:0] tick);
        synapse_out_t r;
        logic signed [15:0] th;
        logic [63:0] elapsed, gd, gr, gm, dm, a, p, mag;
        logic signed [63:0] g;
        int dv;
        bit neg;
        th = reg_shadow[stdes_pkg::REG_THRESHOLD][15:0];
        r.current = 0;
        r.spike = 0;
        if (first)
        begin
            prev_valid = 0;
            fired = reg_shadow[stdes_pkg::REG_START_FIRED][0];
            fire_tick = reg_shadow[stdes_pkg::REG_INIT_FIRE];
        end
        if (prev_valid && $signed(prev_pre) < th && $signed(pre) > th)
        begin
            r.spike = 1;
            fire_tick = tick;
            fired = 1;
        end
        prev_pre = pre;
        prev_valid = 1;
        if (fired)
        begin
            elapsed = (tick >= fire_tick) ? 64'(tick - fire_tick) : 64'd0;
            gd = decay_q30(elapsed * 64'(reg_shadow[stdes_pkg::REG_DECAY][15:0]));
            gr = decay_q30(elapsed * 64'(reg_shadow[stdes_pkg::REG_RISE][15:0]));
            g = $signed(gd) - $signed(gr);
            dv = int'($signed(post)) -
                 int'($signed(reg_shadow[stdes_pkg::REG_REVERSAL][15:0]));
            gm = (g < 0) ? 64'(-g) : 64'(g);
            dm = (dv < 0) ? 64'(-dv) : 64'(dv);
            neg = !((g < 0) != (dv < 0));
            a = 64'(reg_shadow[stdes_pkg::REG_NORM][15:0]) *
                64'(reg_shadow[stdes_pkg::REG_PEAK_COND][15:0]);
            p = (a * gm + (64'd1 << 29)) >> 30;
            mag = (p * dm + (64'd1 << 19)) >> 20;
            if (mag == 0)
                r.current = 0;
            else if (neg)
                r.current = (mag >= 64'h80000000) ? 32'h80000000 : 32'd0 - mag[31:0];
            else
                r.current = (mag >= 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // result check at the falling edge, accepted at the next rising edge
    int quiet_cycles;
    always @(negedge clk)
    begin
        synapse_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (current_q.size() == 0)
            begin
                $error("result with nothing expected: current %h", m_tdata[31:0]);
                errors++;
            end
            else
            begin
                want = current_q.pop_front();
                if (m_tdata[31:0] !== want.current)
                begin
                    $error("synaptic_current expected %h got %h", want.current, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[32] !== want.spike)
                begin
                    $error("spike_detected expected %b got %b", want.spike, m_tdata[32]);
                    errors++;
                end
            end
        end
        // watchdog on accepted items
        if (!rst_n || (m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // drive one item and wait until it is taken
    task automatic send_step(input logic first, input logic [15:0] pre, input logic [15:0] post,
                             input logic [31:0] tick, input bit typed,
                             input synapse_out_t typed_out);
        synapse_out_t r;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= first;
        s_tdata <= {tick, post, pre};
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        r = step_synapse(first, pre, post, tick);
        current_q.push_back(typed ? typed_out : r);
    endtask

    // wait for the block to go idle, then write every register
    task automatic load_registers(input logic [31:0] vals [8]);
        s_tvalid <= 1'b0;
        while (current_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            case (3'(i))
                stdes_pkg::REG_INIT_FIRE:   reg_shadow[i] = vals[i];
                stdes_pkg::REG_START_FIRED: reg_shadow[i] = {31'd0, vals[i][0]};
                default:                    reg_shadow[i] = {16'd0, vals[i][15:0]};
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    step_row_t dir_rows [NUM_ROWS];

    initial
    begin
        logic [31:0] vals [8];
        logic [31:0] tick;
        logic [15:0] pre;
        logic        first;
        synapse_out_t typed_out;
        int run_len, sent, th;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = 0;
        m_tready = 0;
        cfg_we = 0;
        cfg_idx = 0;
        cfg_data = 0;
        errors = 0;
        stall_left = 0;
        quiet_cycles = 0;
        idle_on = 1;

        // exponential tables
        for (int k = 0; k <= stdes_pkg::EXP_TABLE_DEPTH; k++)
            frac_lut[k] = series_q30((64'(k) << 30) / 64'(stdes_pkg::EXP_TABLE_DEPTH));
        int_lut[0] = 32'd1073741824;
        for (int k = 1; k < stdes_pkg::EXP_INT_SPAN; k++)
            int_lut[k] = 32'(((64'(int_lut[k - 1]) *
                               64'(frac_lut[stdes_pkg::EXP_TABLE_DEPTH]))
                              + 64'd536870912) >> 30);

        // reset defaults
        reg_shadow = '{32'd0, 32'd0, 32'd4096, 32'd0, 32'd0, 32'h0000B000, 32'd0, 32'd0};
        prev_pre = 0;
        prev_valid = 0;
        fire_tick = 0;
        fired = 0;

        // directed steps: reset settings first, then strong settings
        dir_rows = '{
            '{1'b0, 16'h8000, 16'h0000, 32'd0,          1'b1, 32'd0, 1'b0},
            '{1'b0, 16'h7FFF, 16'h0000, 32'd1,          1'b1, 32'd0, 1'b1},
            '{1'b1, 16'h0001, 16'h7FFF, 32'd5,          1'b1, 32'd0, 1'b0},
            '{1'b0, 16'h0000, 16'h8000, 32'd6,          1'b1, 32'd0, 1'b0},
            '{1'b0, 16'h0001, 16'h0000, 32'd7,          1'b1, 32'd0, 1'b0},
            '{1'b0, 16'hFFFF, 16'h0000, 32'd8,          1'b1, 32'd0, 1'b0},
            '{1'b0, 16'h0000, 16'h0000, 32'd9,          1'b1, 32'd0, 1'b0},
            '{1'b0, 16'hFFFF, 16'h0000, 32'd10,         1'b1, 32'd0, 1'b0},
            '{1'b0, 16'h0002, 16'h0000, 32'd11,         1'b1, 32'd0, 1'b1},
            '{1'b0, 16'h7FFF, 16'h8000, 32'hFFFFFFFF,   1'b1, 32'd0, 1'b0},
            '{1'b1, 16'h8000, 16'h8000, 32'd500,        1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h8000, 16'h8000, 32'd1001,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h8000, 16'h7FFF, 32'd1003,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'hFF00, 16'h0000, 32'd1010,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h0000, 16'h8000, 32'd1100,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h7FFF, 16'h7FFF, 32'd2000,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h8000, 16'h1234, 32'd2001,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'hFEFF, 16'h0000, 32'd2002,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'hFF01, 16'h8000, 32'd2003,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h0000, 16'h8000, 32'd2010,       1'b0, 32'd0, 1'b0},
            '{1'b0, 16'h0000, 16'h8000, 32'hFFFFFFFF,   1'b0, 32'd0, 1'b0},
            '{1'b1, 16'h0000, 16'h7FFF, 32'd0,          1'b0, 32'd0, 1'b0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (i == SETUP_ROW)
            begin
                vals = '{32'hFFFFFF00, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h1000, 32'h7FFF,
                         32'd1000, 32'd1};
                load_registers(vals);
            end
            typed_out.current = dir_rows[i].current;
            typed_out.spike = dir_rows[i].spike;
            send_step(dir_rows[i].first, dir_rows[i].pre, dir_rows[i].post, dir_rows[i].tick,
                      dir_rows[i].typed, typed_out);
        end

        // random phases, each under its own register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                vals = '{32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h8000,
                         32'hFFFFFFFF, 32'd1};
            else if (ph == 1)
                vals = '{32'h8000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF, 32'd0, 32'd0};
            else
            begin
                vals[0] = $urandom;
                if ($urandom_range(0, 2) != 0)
                    vals[0] = {16'd0, clamp16(int'($urandom_range(0, 8000)) - 4000)};
                vals[1] = $urandom;
                vals[2] = $urandom;
                vals[3] = $urandom >> $urandom_range(16, 28);
                vals[4] = $urandom >> $urandom_range(16, 28);
                vals[5] = $urandom;
                vals[6] = $urandom;
                vals[7] = $urandom;
            end
            idle_on = (ph < NUM_PHASES - 2);
            load_registers(vals);
            th = int'($signed(reg_shadow[stdes_pkg::REG_THRESHOLD][15:0]));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len = $urandom_range(4, 40);
                case ($urandom_range(0, 3))
                    0: tick = reg_shadow[stdes_pkg::REG_INIT_FIRE] - $urandom_range(0, 40);
                    1: tick = reg_shadow[stdes_pkg::REG_INIT_FIRE] + $urandom_range(0, 40);
                    2: tick = $urandom_range(0, 100);
                    default: tick = $urandom;
                endcase
                for (int j = 0; j < run_len && sent < PHASE_ITEMS; j++)
                begin
                    first = (j == 0);
                    if ($urandom_range(0, 11) == 0)
                        first = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 5) == 0)
                        pre = 16'($urandom);
                    else
                        pre = clamp16(th + int'($urandom_range(0, 1600)) - 800);
                    if ($urandom_range(0, 9) == 0)
                        tick = $urandom;
                    else
                        tick = tick + $urandom_range(0, 6);
                    send_step(first, pre, 16'($urandom), tick, 1'b0, typed_out);
                    sent++;
                end
            end
        end

        // drain and finish
        s_tvalid <= 1'b0;
        while (current_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
